@@ sv/grm_pkg.sv @@
package grm_pkg;

  localparam int TsSecW  = 32;
  localparam int TsNsecW = 30;
  localparam int MeanW   = 48;
  localparam int VarW    = 64;
  localparam int CntW    = 16;
  localparam int AlarmW  = 7;
  localparam int RepW    = 32;
  localparam int InDataW  = 168;
  localparam int OutDataW = 200;

  // per-definition accumulator entry
  typedef struct packed {
    logic [TsSecW-1:0]  epoch_sec;
    logic [TsNsecW-1:0] epoch_nsec;
    logic [TsSecW-1:0]  last_sec;
    logic [TsNsecW-1:0] last_nsec;
    logic [MeanW-1:0]   mean;      // signed Q16.32
    logic [VarW-1:0]    var_acc;   // unsigned Q40.24
    logic [CntW-1:0]    cnt;
    logic [AlarmW-1:0]  alarm;     // status 6..2, severity 1..0
    logic [CntW-1:0]    new_cnt;
    logic [RepW-1:0]    rep_cnt;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LOAD, S_EVAL, S_DMEAN, S_DD1, S_MSQ, S_MTERM,
    S_DVAR, S_MBASE, S_CHK, S_DQ, S_SQRT, S_EMIT, S_WB
  } seq_state_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;   // saturated at all ones
  } mul_rsp_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage

@@ sv/grm_div.sv @@
// restoring divider, one quotient bit per cycle
module grm_div
  import grm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [15:0] divisor,
  output div_rsp_t    rsp
);

  logic [16:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [15:0] dsor_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] rem_sh;

  assign rem_sh = {rem_r[15:0], quo_r[63]};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dsor_r}) begin
        rem_nxt = rem_sh - {1'b0, dsor_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) dsor_r <= divisor;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

@@ sv/grm_mul.sv @@
// shift-add multiplier, multiplier bits MSB first, saturating at 64 bits
module grm_mul
  import grm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [31:0] op_b,
  output mul_rsp_t    rsp
);

  logic [63:0] acc_r, acc_nxt, a_r;
  logic [31:0] b_r, b_nxt;
  logic        sat_r, sat_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] sum;

  assign sum = {1'b0, acc_r[62:0], 1'b0} + {1'b0, (b_r[31] ? a_r : 64'd0)};

  always_comb begin
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      b_nxt    = op_b;
      sat_nxt  = 1'b0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = sum[63:0];
      sat_nxt = sat_r | acc_r[63] | sum[64];
      b_nxt   = {b_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
    sat_r <= sat_nxt;
    if (start) a_r <= op_a;
  end

  assign rsp.done = done_r;
  assign rsp.prod = sat_r ? '1 : acc_r;

endmodule

@@ sv/grm_sqrt.sv @@
// restoring integer square root, one root bit per cycle
module grm_sqrt
  import grm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output sqrt_rsp_t   rsp
);

  logic [34:0] rem_r, rem_nxt;
  logic [63:0] v_r, v_nxt;
  logic [31:0] root_r, root_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [34:0] rem_sh, trial;

  assign rem_sh = {rem_r[32:0], v_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    rem_nxt  = rem_r;
    v_nxt    = v_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      v_nxt    = radicand;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt = {v_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    v_r    <= v_nxt;
    root_r <= root_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

@@ sv/gated_running_mean_rms.sv @@
// Per-definition gated running mean and RMS. Each input transfer carries one
// sample for definition in_tuser; in_tlast closes the averaging interval and
// produces one output transfer with mean, sqrt(var/n), count, timestamps,
// worst alarm and counters. Items are handled one at a time; in_tready is
// high only while the sequencer is idle. A repeated timestamp or an item
// that does not enter the average skips the arithmetic; an averaged sample
// adds three serial divides and three serial multiplies; closing an
// interval with a count above one adds one more divide and, unless the
// quotient saturates, a square root. These bit-serial units set the rate.
// The finished result sits in an output register, so the next item can be
// taken while it waits for out_tready (a second result waits until then).
// Per-definition state lives in a memory with a valid bit per entry, so
// reset takes effect at once, with no clearing pass.
module gated_running_mean_rms
  import grm_pkg::*;
#(
  parameter int EDEF_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // sample channel
  input  logic                in_tvalid,
  output logic                in_tready,
  // init_sec[31:0] init_nsec[61:32] severity_limit[64:62] data_sec[96:65]
  // data_nsec[126:97] sample_value[158:127] sample_status[163:159]
  // sample_severity[165:164]
  input  logic [InDataW-1:0]  in_tdata,
  input  logic [3:0]          in_tuser,   // edef_index[3:0]
  input  logic                in_tlast,   // avg_done
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  // mean_value[31:0] rms_value[63:32] sample_count[79:64] last_sec[111:80]
  // last_nsec[141:112] worst_status[146:142] worst_severity[148:147]
  // read_count[164:149] unchanged_count[196:165]
  output logic [OutDataW-1:0] out_tdata,
  output logic [3:0]          out_tuser,  // result_edef[3:0]
  // config: no_average
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  localparam int AW = (EDEF_COUNT > 1) ? $clog2(EDEF_COUNT) : 1;

  // state store
  entry_t                mem [EDEF_COUNT];
  logic [EDEF_COUNT-1:0] vld_r;
  entry_t                rd_q_r;
  logic                  rd_v_r;
  logic [AW-1:0]         addr_r;

  seq_state_t state_r, state_nxt;
  entry_t     ent_r, ent_nxt, ev;
  logic       no_avg_r;

  // latched sample
  logic [3:0]         edef_r;
  logic [TsSecW-1:0]  init_sec_r, data_sec_r;
  logic [TsNsecW-1:0] init_nsec_r, data_nsec_r;
  logic [2:0]         limit_r;
  logic               done_r;
  logic [31:0]        x_r;
  logic [4:0]         stat_r;
  logic [1:0]         sev_r;

  // arithmetic work registers
  logic        neg_r, neg_nxt;
  logic [63:0] dmag_r, dmag_nxt;
  logic [15:0] n_r, n_nxt;
  logic [63:0] term_r, term_nxt;
  logic [31:0] rms_r, rms_nxt;

  logic        out_valid_r, out_load;
  logic [OutDataW-1:0] out_data_r;
  logic [3:0]  out_user_r;

  logic        in_acc, in_range;
  logic        ev_div;
  logic [CntW-1:0] ev_cnt_inc;
  logic [48:0] ev_diff, ev_mag;
  logic [47:0] q48;
  logic [64:0] var_sum;

  logic        div_start, mul_start, sqrt_start;
  logic [63:0] div_dend, mul_a, sqrt_v;
  logic [15:0] div_dsor;
  logic [31:0] mul_b;
  div_rsp_t    div_rsp;
  mul_rsp_t    mul_rsp;
  sqrt_rsp_t   sqrt_rsp;

  grm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(div_dend), .divisor(div_dsor), .rsp(div_rsp)
  );

  grm_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start),
    .op_a(mul_a), .op_b(mul_b), .rsp(mul_rsp)
  );

  grm_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start),
    .radicand(sqrt_v), .rsp(sqrt_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_range  = (32'(in_tuser) < 32'(EDEF_COUNT));
  assign cfg_ready = 1'b1;

  // epoch / timestamp / gating decision for the loaded entry
  always_comb begin
    ev         = ent_r;
    ev_div     = 1'b0;
    ev_cnt_inc = '0;
    if (init_sec_r != ent_r.epoch_sec || init_nsec_r != ent_r.epoch_nsec) begin
      ev.epoch_sec  = init_sec_r;
      ev.epoch_nsec = init_nsec_r;
      ev.mean       = '0;
      ev.var_acc    = '0;
      ev.cnt        = '0;
      ev.new_cnt    = '0;
    end
    if (data_sec_r == ev.last_sec && data_nsec_r == ev.last_nsec) begin
      if (ev.rep_cnt != '1) ev.rep_cnt = ev.rep_cnt + 32'd1;
    end else begin
      ev.last_sec  = data_sec_r;
      ev.last_nsec = data_nsec_r;
      if (ev.new_cnt != '1) ev.new_cnt = ev.new_cnt + 16'd1;
      if ({1'b0, sev_r} < limit_r) begin
        ev_cnt_inc = (ev.cnt != '1) ? ev.cnt + 16'd1 : ev.cnt;
        if (ev_cnt_inc == 16'd1 || no_avg_r) begin
          // restart: first sample of the average
          ev.cnt     = 16'd1;
          ev.mean    = {x_r, 16'd0};
          ev.var_acc = '0;
          ev.alarm   = {stat_r, sev_r};
        end else begin
          ev.cnt = ev_cnt_inc;
          if (sev_r > ev.alarm[1:0]) ev.alarm = {stat_r, sev_r};
          ev_div = 1'b1;
        end
      end
    end
  end

  // x * 2^16 - mean, 49-bit signed, and its magnitude
  assign ev_diff = {x_r[31], x_r, 16'd0} - {ev.mean[47], ev.mean};
  assign ev_mag  = ev_diff[48] ? (49'd0 - ev_diff) : ev_diff;
  assign q48     = div_rsp.quot[47:0];
  assign var_sum = {1'b0, mul_rsp.prod} + {1'b0, term_r};

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    ent_nxt    = ent_r;
    neg_nxt    = neg_r;
    dmag_nxt   = dmag_r;
    n_nxt      = n_r;
    term_nxt   = term_r;
    rms_nxt    = rms_r;
    out_load   = 1'b0;
    div_start  = 1'b0;
    div_dend   = dmag_r;
    div_dsor   = n_r - 16'd1;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    sqrt_v     = {div_rsp.quot[55:0], 8'd0};
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_range) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_LOAD;
      S_LOAD: begin
        ent_nxt   = rd_v_r ? rd_q_r : '0;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        ent_nxt = ev;
        if (ev_div) begin
          neg_nxt   = ev_diff[48];
          dmag_nxt  = {15'd0, ev_mag};
          n_nxt     = ev.cnt;
          div_start = 1'b1;
          div_dend  = {15'd0, ev_mag};
          div_dsor  = ev.cnt;
          state_nxt = S_DMEAN;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_DMEAN: begin
        if (div_rsp.done) begin
          ent_nxt.mean = ent_r.mean + (neg_r ? (48'd0 - q48) : q48);
          div_start    = 1'b1;
          state_nxt    = S_DD1;
        end
      end
      S_DD1: begin
        if (div_rsp.done) begin
          mul_start = 1'b1;
          mul_a     = {32'd0, div_rsp.quot[47:16]};
          mul_b     = div_rsp.quot[47:16];
          state_nxt = S_MSQ;
        end
      end
      S_MSQ: begin
        if (mul_rsp.done) begin
          mul_start = 1'b1;
          mul_a     = {8'd0, mul_rsp.prod[63:8]};
          mul_b     = {16'd0, n_r};
          state_nxt = S_MTERM;
        end
      end
      S_MTERM: begin
        if (mul_rsp.done) begin
          term_nxt  = mul_rsp.prod;
          div_start = 1'b1;
          div_dend  = ent_r.var_acc;
          state_nxt = S_DVAR;
        end
      end
      S_DVAR: begin
        if (div_rsp.done) begin
          mul_start = 1'b1;
          mul_a     = div_rsp.quot;
          mul_b     = {16'd0, n_r - 16'd2};
          state_nxt = S_MBASE;
        end
      end
      S_MBASE: begin
        if (mul_rsp.done) begin
          ent_nxt.var_acc = var_sum[64] ? '1 : var_sum[63:0];
          state_nxt       = S_CHK;
        end
      end
      S_CHK: begin
        if (!done_r) begin
          state_nxt = S_WB;
        end else if (ent_r.cnt > 16'd1) begin
          div_start = 1'b1;
          div_dend  = ent_r.var_acc;
          div_dsor  = ent_r.cnt;
          state_nxt = S_DQ;
        end else begin
          rms_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_DQ: begin
        if (div_rsp.done) begin
          if (div_rsp.quot[63:56] != 8'd0) begin
            rms_nxt   = '1;
            state_nxt = S_EMIT;
          end else begin
            sqrt_start = 1'b1;
            state_nxt  = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        if (sqrt_rsp.done) begin
          rms_nxt   = sqrt_rsp.root;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // wait for the output register, then clear count and mean
        if (!out_valid_r) begin
          out_load     = 1'b1;
          ent_nxt.cnt  = '0;
          ent_nxt.mean = '0;
          state_nxt    = S_WB;
        end
      end
      S_WB: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      no_avg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) no_avg_r <= cfg_data;
      if (state_r == S_WB) vld_r[addr_r] <= 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload and memory
  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r      <= AW'(in_tuser);
      edef_r      <= in_tuser;
      done_r      <= in_tlast;
      init_sec_r  <= in_tdata[31:0];
      init_nsec_r <= in_tdata[61:32];
      limit_r     <= in_tdata[64:62];
      data_sec_r  <= in_tdata[96:65];
      data_nsec_r <= in_tdata[126:97];
      x_r         <= in_tdata[158:127];
      stat_r      <= in_tdata[163:159];
      sev_r       <= in_tdata[165:164];
    end
    if (state_r == S_READ) begin
      rd_q_r <= mem[addr_r];
      rd_v_r <= vld_r[addr_r];
    end
    if (state_r == S_WB) mem[addr_r] <= ent_r;
    ent_r  <= ent_nxt;
    neg_r  <= neg_nxt;
    dmag_r <= dmag_nxt;
    n_r    <= n_nxt;
    term_r <= term_nxt;
    rms_r  <= rms_nxt;
    if (out_load) begin
      out_user_r <= edef_r;
      out_data_r <= {3'd0, ent_r.rep_cnt, ent_r.new_cnt, ent_r.alarm[1:0],
                     ent_r.alarm[6:2], ent_r.last_nsec, ent_r.last_sec,
                     ent_r.cnt, rms_r, ent_r.mean[47:16]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ sv/grm_chk.sv @@
module grm_chk
  import grm_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a result appears only while the sequencer is busy
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result raised while idle");

  a_no_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result one cycle after sample");

  // rms is zero for a count of zero or one
  a_rms_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[79:65] == 15'd0) |-> (out_tdata[63:32] == 32'd0))
    else $error("rms nonzero for count below two");

endmodule

bind gated_running_mean_rms grm_chk u_grm_chk (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import grm_pkg::*;

  localparam int NUM_EDEF    = 16;
  localparam int DRAIN_CYC   = 800;     // longest item plus done path, with margin
  localparam int STALL_LIMIT = 200000;  // cycles with no transfer before giving up
  localparam logic [0:0] CFG_AVERAGE = 1'b0;
  localparam logic [0:0] CFG_NO_AVG  = 1'b1;

  // one sample item, fields at the block's widths
  typedef struct {
    logic [3:0]         edef;
    logic [31:0]        isec;
    logic [29:0]        insec;
    logic               done;
    logic [2:0]         limit;
    logic [31:0]        dsec;
    logic [29:0]        dnsec;
    logic signed [31:0] value;
    logic [4:0]         status;
    logic [1:0]         sevr;
  } sample_t;

  typedef struct {
    logic [3:0]  edef;
    logic [31:0] mean;
    logic [31:0] rms;
    logic [15:0] cnt;
    logic [31:0] lsec;
    logic [29:0] lnsec;
    logic [4:0]  wstat;
    logic [1:0]  wsevr;
    logic [15:0] rd_cnt;
    logic [31:0] rep_cnt;
  } avg_report_t;

  logic clk;
  logic rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [InDataW-1:0] in_tdata;
  logic [3:0] in_tuser;
  logic out_tvalid, out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic [3:0] out_tuser;
  logic cfg_valid, cfg_ready, cfg_data;

  gated_running_mean_rms #(.EDEF_COUNT(NUM_EDEF)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow copy of the per-definition accumulators
  logic [31:0]        sh_epoch_sec  [NUM_EDEF];
  logic [29:0]        sh_epoch_nsec [NUM_EDEF];
  logic [31:0]        sh_last_sec   [NUM_EDEF];
  logic [29:0]        sh_last_nsec  [NUM_EDEF];
  logic signed [63:0] sh_mean       [NUM_EDEF];  // Q16.32 held in 64 bits
  logic [63:0]        sh_var        [NUM_EDEF];  // Q40.24
  logic [15:0]        sh_cnt        [NUM_EDEF];
  logic [6:0]         sh_alarm      [NUM_EDEF];
  logic [15:0]        sh_new_cnt    [NUM_EDEF];
  logic [31:0]        sh_rep_cnt    [NUM_EDEF];
  logic               sh_no_avg;

  avg_report_t pending_reports[$];

  int  n_errors;
  int  n_sent;
  int  n_reports;
  int  idle_cycles;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hot_edef_mode;   // keep several items on one definition to grow counts
  logic [31:0] ts_sec_gen  [NUM_EDEF];
  logic [29:0] ts_nsec_gen [NUM_EDEF];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // fold one averaged sample into definition e
  function automatic void fold_sample(int e, logic signed [31:0] x, logic [4:0] st,
                                      logic [1:0] sv);
    logic signed [63:0] n, diff, d1, xs;
    logic [63:0] a, sq, term, base, nn;
    if (sh_cnt[e] != 16'hFFFF) sh_cnt[e]++;
    xs = 64'(x) <<< 16;
    if (sh_cnt[e] == 16'd1 || sh_no_avg) begin
      sh_cnt[e]   = 16'd1;
      sh_mean[e]  = xs;
      sh_var[e]   = 0;
      sh_alarm[e] = {st, sv};
      return;
    end
    n    = 64'(sh_cnt[e]);
    nn   = 64'(sh_cnt[e]);
    diff = xs - sh_mean[e];
    sh_mean[e] = sh_mean[e] + diff / n;
    d1   = diff / (n - 1);
    a    = (d1 < 0) ? 64'(-d1) : 64'(d1);
    a    = a >> 16;
    sq   = (a * a) >> 8;
    term = (sq > 64'hFFFF_FFFF_FFFF_FFFF / nn) ? 64'hFFFF_FFFF_FFFF_FFFF : sq * nn;
    base = (sh_var[e] / (nn - 1)) * (nn - 2);
    sh_var[e] = (base > 64'hFFFF_FFFF_FFFF_FFFF - term) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                          : base + term;
    if (sv > sh_alarm[e][1:0]) sh_alarm[e] = {st, sv};
  endfunction

  // update shadow state for one accepted item, queue a report when it closes
  function automatic void predict_average(sample_t s);
    int e;
    avg_report_t r;
    logic [63:0] q;
    e = int'(s.edef);
    if (s.isec != sh_epoch_sec[e] || s.insec != sh_epoch_nsec[e]) begin
      sh_epoch_sec[e]  = s.isec;
      sh_epoch_nsec[e] = s.insec;
      sh_mean[e]    = 0;
      sh_var[e]     = 0;
      sh_cnt[e]     = 0;
      sh_new_cnt[e] = 0;
    end
    if (s.dsec == sh_last_sec[e] && s.dnsec == sh_last_nsec[e]) begin
      if (sh_rep_cnt[e] != 32'hFFFF_FFFF) sh_rep_cnt[e]++;
    end else begin
      sh_last_sec[e]  = s.dsec;
      sh_last_nsec[e] = s.dnsec;
      if (sh_new_cnt[e] != 16'hFFFF) sh_new_cnt[e]++;
      if ({1'b0, s.sevr} < s.limit) fold_sample(e, s.value, s.status, s.sevr);
    end
    if (!s.done) return;
    r.rms = 0;
    if (sh_cnt[e] > 1) begin
      q = sh_var[e] / 64'(sh_cnt[e]);
      r.rms = (q >= (64'd1 << 56)) ? 32'hFFFF_FFFF : 32'(isqrt64(q << 8));
    end
    r.edef    = s.edef;
    r.mean    = 32'(sh_mean[e] >>> 16);
    r.cnt     = sh_cnt[e];
    r.lsec    = sh_last_sec[e];
    r.lnsec   = sh_last_nsec[e];
    r.wstat   = sh_alarm[e][6:2];
    r.wsevr   = sh_alarm[e][1:0];
    r.rd_cnt  = sh_new_cnt[e];
    r.rep_cnt = sh_rep_cnt[e];
    pending_reports.push_back(r);
    sh_cnt[e]  = 0;
    sh_mean[e] = 0;
  endfunction

  // valid stays high between back-to-back items; dropped only while idling
  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= s.edef;
    in_tlast  <= s.done;
    in_tdata  <= {2'b0, s.sevr, s.status, s.value, s.dnsec, s.dsec, s.limit,
                  s.insec, s.isec};
    do @(posedge clk); while (!in_tready);
    predict_average(s);
    n_sent++;
  endtask

  // wait for every report, then for the block to finish any silent item
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_no_average(logic val);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sh_no_avg = val;
  endtask

  // random sample for definition e, usually with a fresh timestamp; small steps keep sec/nsec near a pattern
  function automatic sample_t random_sample(int e);
    sample_t s;
    s.edef  = 4'(e);
    s.isec  = sh_epoch_sec[e];
    s.insec = sh_epoch_nsec[e];
    if ($urandom_range(99) < 4) begin
      s.isec  = $urandom;
      s.insec = 30'($urandom);
    end
    s.done  = ($urandom_range(99) < 12);
    s.limit = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    if ($urandom_range(99) < 10) begin
      s.dsec  = sh_last_sec[e];
      s.dnsec = sh_last_nsec[e];
    end else begin
      ts_nsec_gen[e] = ts_nsec_gen[e] + 30'($urandom_range(1, 50_000_000));
      if (ts_nsec_gen[e] > 30'd999_999_999 || $urandom_range(99) < 20) begin
        ts_nsec_gen[e] = 30'($urandom_range(999_999_999));
        ts_sec_gen[e]  = ts_sec_gen[e] + 1;
      end
      if ($urandom_range(99) < 3) ts_sec_gen[e] = $urandom;
      s.dsec  = ts_sec_gen[e];
      s.dnsec = ($urandom_range(99) < 3) ? 30'($urandom) : ts_nsec_gen[e];
    end
    case ($urandom_range(3))
      0:       s.value = $urandom;
      1:       s.value = 32'($signed($urandom_range(4000)) - 2000) <<< 16;
      2:       s.value = 32'sh0010_0000 + 32'($signed($urandom_range(2000)) - 1000);
      default: s.value = ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
    s.status = 5'($urandom);
    s.sevr   = 2'($urandom);
    return s;
  endfunction

  // result checker
  always @(posedge clk) begin
    avg_report_t x;
    if (rst_n && out_tvalid && out_tready) begin
      n_reports++;
      if (pending_reports.size() == 0) begin
        $error("unexpected result transfer edef=%0d", out_tuser);
        n_errors++;
      end else begin
        x = pending_reports.pop_front();
        if (out_tuser != x.edef) begin
          $error("result_edef exp %0d got %0d", x.edef, out_tuser); n_errors++;
        end
        if (out_tdata[31:0] != x.mean) begin
          $error("mean_value exp %h got %h", x.mean, out_tdata[31:0]); n_errors++;
        end
        if (out_tdata[63:32] != x.rms) begin
          $error("rms_value exp %h got %h", x.rms, out_tdata[63:32]); n_errors++;
        end
        if (out_tdata[79:64] != x.cnt) begin
          $error("sample_count exp %0d got %0d", x.cnt, out_tdata[79:64]); n_errors++;
        end
        if (out_tdata[111:80] != x.lsec) begin
          $error("last_sec exp %h got %h", x.lsec, out_tdata[111:80]); n_errors++;
        end
        if (out_tdata[141:112] != x.lnsec) begin
          $error("last_nsec exp %h got %h", x.lnsec, out_tdata[141:112]); n_errors++;
        end
        if (out_tdata[146:142] != x.wstat) begin
          $error("worst_status exp %0d got %0d", x.wstat, out_tdata[146:142]);
          n_errors++;
        end
        if (out_tdata[148:147] != x.wsevr) begin
          $error("worst_severity exp %0d got %0d", x.wsevr, out_tdata[148:147]);
          n_errors++;
        end
        if (out_tdata[164:149] != x.rd_cnt) begin
          $error("read_count exp %0d got %0d", x.rd_cnt, out_tdata[164:149]);
          n_errors++;
        end
        if (out_tdata[196:165] != x.rep_cnt) begin
          $error("unchanged_count exp %0d got %0d", x.rep_cnt, out_tdata[196:165]);
          n_errors++;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: count cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // directed: field extremes, repeats, epoch change, limits, empty close
  task automatic test_directed();
    sample_t s;
    s = '{edef: 4'd0, isec: 32'd0, insec: 30'd0, done: 1'b0, limit: 3'd4,
          dsec: 32'd0, dnsec: 30'd0, value: 32'sd0, status: 5'd0, sevr: 2'd0};
    send_sample(s);                       // zero timestamp after reset: a repeat
    s.done = 1'b1;
    send_sample(s);                       // close with no samples
    s.done = 1'b0; s.dsec = 32'd1; s.value = 32'sh7FFF_FFFF; s.status = 5'd31;
    s.sevr = 2'd1;
    send_sample(s);
    s.dsec = 32'd2; s.value = 32'sh8000_0000; s.sevr = 2'd3; s.status = 5'd7;
    send_sample(s);                       // severity invalid, limit above three
    s.dsec = 32'hFFFF_FFFF; s.dnsec = 30'h3FFF_FFFF; s.value = 32'sh0001_0000;
    s.sevr = 2'd2; s.status = 5'd17;
    send_sample(s);                       // nanoseconds out of range
    s.done = 1'b1;
    send_sample(s);                       // repeat timestamp while closing
    s.done = 1'b0; s.limit = 3'd0; s.dsec = 32'd5; s.dnsec = 30'd999_999_999;
    send_sample(s);                       // limit zero: nothing averaged
    s.limit = 3'd2; s.dsec = 32'd6; s.sevr = 2'd2;
    send_sample(s);                       // severity equal to limit: rejected
    s.sevr = 2'd1; s.dsec = 32'd7; s.value = -32'sd5;
    send_sample(s);
    s.dsec = 32'd8; s.value = 32'sd12345; s.done = 1'b1;
    send_sample(s);
    s = '{edef: 4'd15, isec: 32'hFFFF_FFFF, insec: 30'd999_999_999, done: 1'b0,
          limit: 3'd7, dsec: 32'd10, dnsec: 30'd1, value: 32'sh0003_0000,
          status: 5'd3, sevr: 2'd0};
    send_sample(s);
    s.dnsec = 30'd2; s.value = -32'sh0003_0000;
    send_sample(s);
    s.insec = 30'd5; s.dnsec = 30'd3; s.done = 1'b1;
    send_sample(s);                       // epoch change clears sums
    s.insec = 30'h2AAA_AAAA; s.isec = 32'h5555_5555; s.dsec = 32'hAAAA_AAAA;
    s.dnsec = 30'h1555_5555; s.value = 32'sh5555_5555;
    send_sample(s);
    wait_idle();
  endtask

  task automatic test_random(int n_items, int sidle, int rstall);
    int e;
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    e = 0;
    repeat (n_items) begin
      if (!hot_edef_mode || $urandom_range(9) == 0) e = int'($urandom_range(NUM_EDEF - 1));
      send_sample(random_sample(e));
    end
    wait_idle();
  endtask

  // restart-on-every-sample mode, then back to averaging
  task automatic test_no_average();
    write_no_average(CFG_NO_AVG);
    test_random(150, 0, 0);
    wait_idle();
    write_no_average(CFG_AVERAGE);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0; in_tlast = 1'b0;
    out_tready = 1'b0; cfg_valid = 1'b0; cfg_data = 1'b0;
    n_errors = 0; n_sent = 0; n_reports = 0; idle_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hot_edef_mode = 1'b1;
    sh_no_avg = 1'b0;
    for (int i = 0; i < NUM_EDEF; i++) begin
      sh_epoch_sec[i] = 0; sh_epoch_nsec[i] = 0; sh_last_sec[i] = 0;
      sh_last_nsec[i] = 0; sh_mean[i] = 0; sh_var[i] = 0; sh_cnt[i] = 0;
      sh_alarm[i] = 0; sh_new_cnt[i] = 0; sh_rep_cnt[i] = 0;
      ts_sec_gen[i] = 32'd100; ts_nsec_gen[i] = 30'd0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_no_average(CFG_AVERAGE);
    test_directed();
    test_random(400, 0, 0);
    test_random(350, 72, 0);
    test_random(350, 0, 72);
    test_no_average();
    hot_edef_mode = 1'b0;
    test_random(350, 18, 18);
    hot_edef_mode = 1'b1;
    test_random(100, 0, 0);

    $display("Sent %0d samples over 16 definitions, checked %0d averaging results,",
             n_sent, n_reports);
    $display("with both averaging modes and sender/receiver idling phases.");
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/grm_pkg.sv
sv/grm_div.sv
sv/grm_mul.sv
sv/grm_sqrt.sv
sv/gated_running_mean_rms.sv
sv/grm_chk.sv
tb/testbench.sv
